### hdl/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skid-steer mixer package
// Shared item types, the motion state type, pipeline types and the fixed
// constants of the duty mapping and the divide by ninety.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // Input item: steering angle, speed request and four measured wheel speeds.
    typedef struct packed {
        logic signed [8:0] steer_angle;
        logic [6:0]        speed_request;
        logic [11:0]       rpm_front_left;
        logic [11:0]       rpm_front_right;
        logic [11:0]       rpm_back_left;
        logic [11:0]       rpm_back_right;
    } t_ssm_in;

    // Result item: four wheel duties in unsigned Q7.8 percent and side directions.
    typedef struct packed {
        logic [14:0] duty_front_left;
        logic [14:0] duty_front_right;
        logic [14:0] duty_back_left;
        logic [14:0] duty_back_right;
        logic        left_reverse;
        logic        right_reverse;
    } t_ssm_out;

    // Stored motion direction of the vehicle.
    typedef enum logic [1:0] {
        MOT_STOPPED  = 2'd0,
        MOT_FORWARD  = 2'd1,
        MOT_BACKWARD = 2'd2
    } t_motion;

    // Values passed from the steering stage to the scaling stage.
    typedef struct packed {
        logic [21:0] product;      // set duty times the steering factor
        logic [14:0] base_duty;    // duty of any side that is not scaled
        logic        scale_left;
        logic        scale_right;
        logic        left_reverse;
        logic        right_reverse;
    } t_ssm_mid;

    // Configuration register indexes.
    localparam logic CFG_BRAKE_DUTY = 1'b0;
    localparam logic CFG_STOP_RPM   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [6:0]  BRAKE_DUTY_RESET = 7'd100;
    localparam logic [11:0] STOP_RPM_RESET   = 12'd10;

    // Angle and speed limits.
    localparam logic signed [8:0] ANGLE_MAX     = 9'sd180;
    localparam logic signed [8:0] ANGLE_MIN     = -9'sd180;
    localparam logic [7:0]        ANGLE_QUARTER = 8'd90;
    localparam logic [6:0]        PERCENT_MAX   = 7'd100;

    // Divide by ninety: floor(p / 90) = (p * RECIP_MULT) >> RECIP_SHIFT for p < 2^22.
    localparam int               RECIP_SHIFT = 29;
    localparam logic [22:0]      RECIP_MULT  = 23'd5965233;

endpackage

### hdl/four_wheel_skid_steer_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-wheel skid-steer mixer
// Maps a steering angle and speed request to four wheel duties and two side
// directions, with braking against the stored motion direction.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in_valid / o_in_ready with payload i_in, results
// leave on o_out_valid / i_out_ready with payload o_out. Every input item
// gives exactly one result item, in order.
// The block is a three-register pipeline: input register, steering stage
// register (after the product multiply), and result register (after the
// divide by ninety). One item is accepted per cycle while the receiver
// takes results; the two multipliers are each followed by a register.
// When the receiver stalls, the stages fill and o_in_ready drops once all
// three hold items; nothing is dropped or repeated.
// Configuration writes on i_cfg_valid / o_cfg_ready are always taken:
// index 0 is the brake duty, index 1 the stop RPM threshold. Write them
// only while the pipeline is empty.
// Reset clears the pipeline, sets the motion state to stopped and loads
// brake duty 100 and stop threshold 10.
// ----------------------------------------------------------------------------
module four_wheel_skid_steer_mixer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ssm_pkg::t_ssm_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ssm_pkg::t_ssm_out o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import ssm_pkg::*;

    logic       r_v0;
    logic       r_v1;
    logic       r_v2;
    t_ssm_in    r_in;
    t_ssm_mid   r_mid;
    t_ssm_out   r_out;
    t_motion    r_motion;
    logic [6:0] r_brake_duty;
    logic [11:0] r_stop_rpm;

    t_ssm_mid   n_mid;
    t_ssm_out   n_out;
    t_motion    n_motion;
    logic       en0;
    logic       en1;
    logic       en2;

    // A stage moves when its downstream slot is empty or moving too.
    assign en2 = !r_v2 || i_out_ready;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign o_in_ready  = en0;
    assign o_out_valid = r_v2;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Steering stage.
    ssm_steer u_steer (
        .i_item        (r_in),
        .i_brake_duty  (r_brake_duty),
        .i_stop_rpm    (r_stop_rpm),
        .i_motion      (r_motion),
        .o_mid         (n_mid),
        .o_motion_next (n_motion)
    );

    // Scaling stage.
    ssm_scale u_scale (
        .i_mid  (r_mid),
        .o_item (n_out)
    );

    // Pipeline valid bits, motion state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_motion     <= MOT_STOPPED;
            r_brake_duty <= BRAKE_DUTY_RESET;
            r_stop_rpm   <= STOP_RPM_RESET;
        end else begin
            if (en0) begin
                r_v0 <= i_in_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en1 && r_v0) begin
                r_motion <= n_motion;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BRAKE_DUTY: r_brake_duty <= i_cfg_data[6:0];
                    CFG_STOP_RPM:   r_stop_rpm   <= i_cfg_data;
                    default:        r_stop_rpm   <= r_stop_rpm;
                endcase
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (en0 && i_in_valid) begin
            r_in <= i_in;
        end
        if (en1 && r_v0) begin
            r_mid <= n_mid;
        end
        if (en2 && r_v1) begin
            r_out <= n_out;
        end
    end

endmodule

### hdl/ssm_steer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skid-steer mixer steering stage
// Saturates the angle, request and brake duty, sets the base duty, forms the
// steering product for the inner side, picks the side directions and the next
// motion state, including braking against motion at a zero request.
// ----------------------------------------------------------------------------
module ssm_steer (
    input  ssm_pkg::t_ssm_in  i_item,
    input  logic [6:0]        i_brake_duty,
    input  logic [11:0]       i_stop_rpm,
    input  ssm_pkg::t_motion  i_motion,
    output ssm_pkg::t_ssm_mid o_mid,
    output ssm_pkg::t_motion  o_motion_next
);
    import ssm_pkg::*;

    logic signed [8:0] angle;
    logic [7:0]        mag;
    logic [6:0]        factor;
    logic [6:0]        req;
    logic [6:0]        brake;
    logic [7:0]        req_sum;
    logic [14:0]       set_duty;
    logic [14:0]       brake_duty;
    logic              moving;
    logic              go_fwd;
    logic              go_rev;
    logic              spin_right;
    logic              spin_left;
    logic              below_stop;
    t_motion           motion_mid;

    // Saturate the angle and the request, then take the angle magnitude.
    always_comb begin
        if (i_item.steer_angle > ANGLE_MAX) begin
            angle = ANGLE_MAX;
        end else if (i_item.steer_angle < ANGLE_MIN) begin
            angle = ANGLE_MIN;
        end else begin
            angle = i_item.steer_angle;
        end
        mag = angle[8] ? 8'(-angle) : 8'(angle);
        req = (i_item.speed_request > PERCENT_MAX) ? PERCENT_MAX : i_item.speed_request;
        brake = (i_brake_duty > PERCENT_MAX) ? PERCENT_MAX : i_brake_duty;
    end

    // Set duty is 128 * (request + 100), which is request/2 + 50 percent in Q7.8.
    assign req_sum    = 8'(req) + 8'(PERCENT_MAX);
    assign set_duty   = {req_sum, 7'b0};
    assign brake_duty = {brake, 8'b0};
    assign moving     = (req != 7'd0);

    // Inner side factor: distance of the angle magnitude from ninety degrees.
    assign factor = (mag < ANGLE_QUARTER) ? 7'(ANGLE_QUARTER - mag) : 7'(mag - ANGLE_QUARTER);

    assign go_fwd     = moving && (mag < ANGLE_QUARTER);
    assign go_rev     = moving && (mag > ANGLE_QUARTER);
    assign spin_right = (mag == ANGLE_QUARTER) && !angle[8];
    assign spin_left  = (mag == ANGLE_QUARTER) && angle[8];

    assign below_stop = (i_item.rpm_front_left < i_stop_rpm) ||
                        (i_item.rpm_front_right < i_stop_rpm) ||
                        (i_item.rpm_back_left < i_stop_rpm) ||
                        (i_item.rpm_back_right < i_stop_rpm);

    // Directions, duties and motion state, with braking at a zero request.
    always_comb begin
        o_mid.product       = {15'(req_sum) * 15'(factor), 7'b0};
        o_mid.scale_left    = moving && angle[8] && !spin_left;
        o_mid.scale_right   = moving && !angle[8] && (mag != 8'd0) && !spin_right;
        o_mid.left_reverse  = go_rev || spin_left;
        o_mid.right_reverse = go_rev || spin_right;
        o_mid.base_duty     = set_duty;

        if (go_fwd) begin
            motion_mid = MOT_FORWARD;
        end else if (go_rev) begin
            motion_mid = MOT_BACKWARD;
        end else if (spin_right || spin_left) begin
            motion_mid = MOT_STOPPED;
        end else begin
            motion_mid = i_motion;
        end
        o_motion_next = motion_mid;

        if (!moving) begin
            case (motion_mid)
                MOT_FORWARD: begin
                    o_mid.left_reverse  = 1'b1;
                    o_mid.right_reverse = 1'b1;
                    o_mid.base_duty     = brake_duty;
                    o_motion_next       = MOT_BACKWARD;
                end
                MOT_BACKWARD: begin
                    o_mid.left_reverse  = 1'b0;
                    o_mid.right_reverse = 1'b0;
                    o_mid.base_duty     = brake_duty;
                    o_motion_next       = MOT_FORWARD;
                end
                default: begin
                    o_mid.base_duty = 15'd0;
                end
            endcase
            if (below_stop) begin
                o_motion_next = MOT_STOPPED;
            end
        end
    end

endmodule

### hdl/ssm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skid-steer mixer scaling stage
// Divides the steering product by ninety with a reciprocal multiply and
// assembles the four wheel duties and the side directions.
// ----------------------------------------------------------------------------
module ssm_scale (
    input  ssm_pkg::t_ssm_mid i_mid,
    output ssm_pkg::t_ssm_out o_item
);
    import ssm_pkg::*;

    logic [44:0] recip_prod;
    logic [14:0] scaled;

    // Exact floor division by ninety over the whole product range.
    assign recip_prod = 45'(i_mid.product) * 45'(RECIP_MULT);
    assign scaled     = recip_prod[RECIP_SHIFT +: 15];

    // Inner side takes the scaled duty, the other side the base duty.
    always_comb begin
        o_item.duty_front_left  = i_mid.scale_left ? scaled : i_mid.base_duty;
        o_item.duty_back_left   = i_mid.scale_left ? scaled : i_mid.base_duty;
        o_item.duty_front_right = i_mid.scale_right ? scaled : i_mid.base_duty;
        o_item.duty_back_right  = i_mid.scale_right ? scaled : i_mid.base_duty;
        o_item.left_reverse     = i_mid.left_reverse;
        o_item.right_reverse    = i_mid.right_reverse;
    end

endmodule
